// ----- rtl/wcmp_pkg.sv -----
// Shared types, widths and constants of the waveform column min/peak block.
package wcmp_pkg;

  // Field widths.
  localparam int ROW_W      = 12;
  localparam int SPC_W      = 16;
  localparam int COL_W      = 13;
  localparam int SCALE_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 16;
  localparam int CIDX_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BYTE_W     = 8;

  // Row mapping arithmetic.
  localparam int Q_SHIFT     = 12;
  localparam int AMP_W       = 16;
  localparam int PROD_W      = 2 * (AMP_W + 1);
  localparam int QUO_W       = 18;
  localparam int RECIP_X_W   = 24;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_255 = 25'h1010102;
  localparam int HALF_SHIFT  = 15;
  localparam int HALF_BIAS   = (1 << HALF_SHIFT) - 1;

  // Depth of the queue between mapper and folder.
  localparam int FIFO_DEPTH = 8;

  // Register values after reset.
  localparam int HEIGHT_RST = 100;
  localparam int SPC_RST    = 1;
  localparam int COLS_RST   = 1;
  localparam int SCALE_RST  = 4096;
  localparam logic [AMP_W-1:0] AMP_RST =
    AMP_W'(((HEIGHT_RST / 2) * SCALE_RST) >> Q_SHIFT);

  typedef enum logic {
    MODE_U8  = 1'b0,
    MODE_S16 = 1'b1
  } width_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT = 3'd0,
    CFG_SPC    = 3'd1,
    CFG_COLS   = 3'd2,
    CFG_SCALE  = 3'd3,
    CFG_MODE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ROW_W-1:0]   height;
    logic [SPC_W-1:0]   spc;
    logic [COL_W-1:0]   cols;
    logic [SCALE_W-1:0] scale;
    width_mode_e        mode;
  } cfg_t;

endpackage

// ----- rtl/wcmp_cfg.sv -----
// Configuration register file of the waveform column min/peak block.
module wcmp_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wcmp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wcmp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output wcmp_pkg::cfg_t                      cfg_o
);

  wcmp_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height <= wcmp_pkg::ROW_W'(wcmp_pkg::HEIGHT_RST);
      cfg_q.spc    <= wcmp_pkg::SPC_W'(wcmp_pkg::SPC_RST);
      cfg_q.cols   <= wcmp_pkg::COL_W'(wcmp_pkg::COLS_RST);
      cfg_q.scale  <= wcmp_pkg::SCALE_W'(wcmp_pkg::SCALE_RST);
      cfg_q.mode   <= wcmp_pkg::MODE_S16;
    end else if (cfg_valid_i) begin
      case (wcmp_pkg::cfg_idx_e'(cfg_index_i))
        wcmp_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data_i[wcmp_pkg::ROW_W-1:0];
        wcmp_pkg::CFG_SPC:    cfg_q.spc    <= cfg_data_i[wcmp_pkg::SPC_W-1:0];
        wcmp_pkg::CFG_COLS:   cfg_q.cols   <= cfg_data_i[wcmp_pkg::COL_W-1:0];
        wcmp_pkg::CFG_SCALE:  cfg_q.scale  <= cfg_data_i[wcmp_pkg::SCALE_W-1:0];
        wcmp_pkg::CFG_MODE:   cfg_q.mode   <= wcmp_pkg::width_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/wcmp_front.sv -----
// Front end: accepts samples and maps each one to a clamped display row.
module wcmp_front #(
  parameter int DEPTH = wcmp_pkg::FIFO_DEPTH,
  parameter int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wcmp_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [wcmp_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [LVL_W-1:0]                    level_i,
  output logic                                push_o,
  output logic [wcmp_pkg::ROW_W-1:0]          push_row_o
);

  localparam int ROW_W  = wcmp_pkg::ROW_W;
  localparam int AMP_W  = wcmp_pkg::AMP_W;
  localparam int PROD_W = wcmp_pkg::PROD_W;
  localparam int QUO_W  = wcmp_pkg::QUO_W;
  localparam int S_W    = wcmp_pkg::SAMPLE_W;

  logic                               mode_s16;
  logic [ROW_W-1:0]                   base;
  logic [ROW_W+wcmp_pkg::SCALE_W-1:0] amp_prod;
  logic [AMP_W-1:0]                   amp_d, amp_q;
  logic                               amp_ok;
  logic [LVL_W:0]                     occ;
  logic                               accept;
  logic signed [S_W:0]                s_ext;
  logic signed [AMP_W:0]              amp_s;
  logic signed [PROD_W-1:0]           prod_d, prod_q;
  logic                               va_q, vb_q;
  logic [wcmp_pkg::RECIP_X_W+wcmp_pkg::RECIP_W-1:0] recip_prod;
  logic signed [PROD_W-1:0]           bias, biased;
  logic signed [QUO_W-1:0]            q8, q16, q_d, q_q;
  logic signed [QUO_W:0]              row_s;

  assign mode_s16 = (cfg_i.mode == wcmp_pkg::MODE_S16);

  // Row offset: half height for signed samples, full height for bytes.
  assign base = mode_s16 ? {1'b0, cfg_i.height[ROW_W-1:1]} : cfg_i.height;

  // Amplitude in rows, refreshed every cycle from the registers.
  assign amp_prod = base * cfg_i.scale;
  assign amp_d    = amp_prod[wcmp_pkg::Q_SHIFT +: AMP_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= wcmp_pkg::AMP_RST;
    end else begin
      amp_q <= amp_d;
    end
  end

  // The amplitude register lags a register write by one register; no item is
  // taken until it has caught up.
  assign amp_ok = (amp_q == amp_d);

  // Take an item only when the queue has room for everything in flight.
  assign occ = (LVL_W + 1)'(level_i) + (LVL_W + 1)'(va_q) + (LVL_W + 1)'(vb_q);
  assign in_ready_o = (occ < (LVL_W + 1)'(DEPTH)) && amp_ok;
  assign accept     = in_valid_i && in_ready_o;

  // Stage A: sample times amplitude.
  always_comb begin
    if (mode_s16) begin
      s_ext = {sample_i[S_W-1], sample_i};
    end else begin
      s_ext = $signed({{(S_W + 1 - wcmp_pkg::BYTE_W){1'b0}},
                       sample_i[wcmp_pkg::BYTE_W-1:0]});
    end
  end

  assign amp_s  = $signed({1'b0, amp_q});
  assign prod_d = s_ext * amp_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
    end
  end

  // Stage B: byte mode divides by 255 through a reciprocal, exact below 2^24;
  // signed mode divides by 32768 with truncation toward zero.
  assign recip_prod = prod_q[wcmp_pkg::RECIP_X_W-1:0] * wcmp_pkg::RECIP_255;
  assign q8 = $signed({1'b0, recip_prod[wcmp_pkg::RECIP_SHIFT +: QUO_W-1]});

  assign bias   = prod_q[PROD_W-1] ? PROD_W'(wcmp_pkg::HALF_BIAS) : '0;
  assign biased = prod_q + bias;
  assign q16    = biased[wcmp_pkg::HALF_SHIFT +: QUO_W];
  assign q_d    = mode_s16 ? q16 : q8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q) begin
      q_q <= q_d;
    end
  end

  // Row and clamp to 0..height, written straight into the queue.
  assign row_s = $signed({{(QUO_W + 1 - ROW_W){1'b0}}, base}) - q_q;

  always_comb begin
    if (row_s[QUO_W]) begin
      push_row_o = '0;
    end else if (row_s > $signed({{(QUO_W + 1 - ROW_W){1'b0}}, cfg_i.height})) begin
      push_row_o = cfg_i.height;
    end else begin
      push_row_o = row_s[ROW_W-1:0];
    end
  end

  assign push_o = vb_q;

  // The credit check must keep the queue from ever being oversubscribed.
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (LVL_W + 1)'(DEPTH))
    else $error("front: items in flight exceed queue depth");

endmodule

// ----- rtl/wcmp_fifo.sv -----
// Short queue of mapped rows between the front end and the column folder.
module wcmp_fifo #(
  parameter int DEPTH = wcmp_pkg::FIFO_DEPTH,
  parameter int WIDTH = wcmp_pkg::ROW_W,
  parameter int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic [LVL_W-1:0] level_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0] level_q;

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 1'b1;
      end else if (!push_i && pop_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (level_q < LVL_W'(DEPTH)) || pop_i)
    else $error("fifo: push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("fifo: pop from an empty queue");

endmodule

// ----- rtl/wcmp_back.sv -----
// Back end: folds rows into the column minimum and peak and emits columns.
module wcmp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wcmp_pkg::cfg_t                    cfg_i,
  input  logic                              row_valid_i,
  input  logic [wcmp_pkg::ROW_W-1:0]        row_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wcmp_pkg::ROW_W-1:0]        column_min_o,
  output logic [wcmp_pkg::ROW_W-1:0]        column_peak_o,
  output logic [wcmp_pkg::CIDX_W-1:0]       column_index_o,
  output logic                              last_column_o
);

  localparam int ROW_W  = wcmp_pkg::ROW_W;
  localparam int CNT_W  = wcmp_pkg::CNT_W;
  localparam int CIDX_W = wcmp_pkg::CIDX_W;

  logic [ROW_W-1:0]  min_q, peak_q, row_min, row_peak;
  logic [CNT_W-1:0]  cnt_q, cnt_inc;
  logic [CIDX_W-1:0] col_q;
  logic [CIDX_W:0]   col_inc;
  logic              close, last, out_free, out_valid_q;

  // Fold the row and decide whether it closes the column.
  assign row_min  = (row_i < min_q)  ? row_i : min_q;
  assign row_peak = (row_i > peak_q) ? row_i : peak_q;
  assign cnt_inc  = cnt_q + 1'b1;
  assign close    = (cnt_inc == '0) || (cnt_inc >= cfg_i.spc);
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign last     = (col_inc >= cfg_i.cols);

  // A closing item waits only while the output register is still full.
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = row_valid_i && (!close || out_free);

  // Running column state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= ROW_W'(wcmp_pkg::HEIGHT_RST);
      peak_q <= '0;
      cnt_q  <= '0;
      col_q  <= '0;
    end else if (pop_o) begin
      if (close) begin
        min_q  <= cfg_i.height;
        peak_q <= '0;
        cnt_q  <= '0;
        col_q  <= last ? '0 : col_inc[CIDX_W-1:0];
      end else begin
        min_q  <= row_min;
        peak_q <= row_peak;
        cnt_q  <= cnt_inc;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && close) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (pop_o && close) begin
      column_min_o   <= row_min;
      column_peak_o  <= row_peak;
      column_index_o <= col_q;
      last_column_o  <= last;
    end
  end

  assign out_valid_o = out_valid_q;

  a_close_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && close) |=> (out_valid_q && (cnt_q == '0)))
    else $error("back: closed column did not reach the output register");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && close && last) |=> (col_q == '0) && last_column_o)
    else $error("back: last column did not wrap the column index");

endmodule

// ----- rtl/waveform_column_min_peak_top.sv -----
// Top level of the waveform column min/peak decimator.
//
// Audio samples enter on the in channel (in_valid_i/in_ready_o, sample_i), one
// item per sample. Each sample is mapped to a display row, clamped to
// 0..height, and folded into the running minimum and peak of the current
// column. After samples_per_column samples one result item leaves on the out
// channel with the column's minimum, peak, index and a last-column flag.
// Registers are written through the cfg channel (index, data); writes are
// always taken and must only happen while the block is idle. A write that
// changes the amplitude holds in_ready_o low for the following cycle.
// Throughput is one item per cycle while the queue has room. A result is shown
// once the sample that closes its column has passed the divide stage and the
// queue write and the folder has loaded the output register.
// An eight-entry row queue between mapper and folder, guarded by a credit
// count, sets how far the front end runs ahead while the receiver stalls;
// when it fills, in_ready_o drops. Samples that close no column keep flowing
// while a result waits in the output register.
// Reset loads the register defaults and empties the pipeline and queue.
module waveform_column_min_peak_top #(
  parameter int FIFO_DEPTH = wcmp_pkg::FIFO_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wcmp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wcmp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wcmp_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [wcmp_pkg::ROW_W-1:0]           column_min_o,
  output logic [wcmp_pkg::ROW_W-1:0]           column_peak_o,
  output logic [wcmp_pkg::CIDX_W-1:0]          column_index_o,
  output logic                                 last_column_o
);

  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  wcmp_pkg::cfg_t              cfg;
  logic                        push, pop, row_valid;
  logic [wcmp_pkg::ROW_W-1:0]  push_row, row;
  logic [LVL_W-1:0]            level;

  wcmp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wcmp_front #(
    .DEPTH (FIFO_DEPTH),
    .LVL_W (LVL_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .level_i    (level),
    .push_o     (push),
    .push_row_o (push_row)
  );

  wcmp_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (wcmp_pkg::ROW_W),
    .LVL_W (LVL_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_row),
    .pop_i       (pop),
    .valid_o     (row_valid),
    .data_o      (row),
    .level_o     (level)
  );

  wcmp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .row_valid_i    (row_valid),
    .row_i          (row),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .column_min_o   (column_min_o),
    .column_peak_o  (column_peak_o),
    .column_index_o (column_index_o),
    .last_column_o  (last_column_o)
  );

endmodule
